FILE: rtl/core/cpfcd_pkg.sv
// ----------------------------------------------------------------------------
// cpfcd_pkg
// Shared widths, constants, token type and mod-11 helpers for the CPF
// check-digit core.
// ----------------------------------------------------------------------------
package cpfcd_pkg;

  localparam int BASE_W      = 30;
  localparam int SUM_W       = 10;  // second sum peaks at 585
  localparam int DIGIT_W     = 4;
  localparam int FULL_W      = 37;
  localparam int BASE_DIGITS = 9;
  localparam int MODULUS     = 11;

  localparam logic [BASE_W-1:0] BASE_LIMIT = BASE_W'(999999999);

  // floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT, exact for any 32-bit x
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;
  localparam int          PROD10_W      = BASE_W + 32;

  // floor(s / 11) = (s * RECIP11) >> RECIP11_SHIFT, exact for s below 2730
  localparam logic [SUM_W:0] RECIP11       = (SUM_W+1)'(1490);
  localparam int             RECIP11_SHIFT = 14;
  localparam int             PROD11_W      = 2 * SUM_W + 4;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] rest;
    logic [SUM_W-1:0]  sum1;
    logic [SUM_W-1:0]  sum2;
    logic              oor;
  } token_t;

  function automatic logic [DIGIT_W-1:0] mod11(input logic [SUM_W-1:0] s);
    logic [PROD11_W-1:0] p;
    logic [SUM_W-1:0]    q;
    logic [SUM_W-1:0]    qx11;
    p    = PROD11_W'(s) * PROD11_W'(RECIP11);
    q    = SUM_W'(p >> RECIP11_SHIFT);
    qx11 = SUM_W'((q << 3) + (q << 1) + q);
    return DIGIT_W'(s - qx11);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_from_sum(input logic [SUM_W-1:0] s);
    logic [DIGIT_W-1:0] r;
    r = mod11(s);
    return (r < DIGIT_W'(2)) ? '0 : (DIGIT_W'(MODULUS) - r);
  endfunction

endpackage

FILE: rtl/core/cpf_check_digit_calculator_core.sv
// ----------------------------------------------------------------------------
// cpf_check_digit_calculator_core
// CPF check-digit generator (mod 11): streams nine-digit base numbers and
// returns both check digits with the eleven-digit full number.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | into core | in_valid/in_stall  | base_number[29:0]
//  out_    | from core | out_valid/out_stall| first_digit, second_digit,
//          |           |                    | full_number[36:0], out_of_range
//
//  One transfer per cycle in each direction when neither side stalls.
//  The pipeline is nine digit cells, then two check stages; the
//  reciprocal multiply inside each digit cell sets the stage depth.
//  Reset (rst_n low, synchronous) empties every stage; no clearing pass.
//  A stall on the output holds the last stage; upstream stages keep
//  filling any empty slot, so bubbles are squeezed out during a stall.
//
module cpf_check_digit_calculator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cpfcd_pkg::BASE_W-1:0]  in_base_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cpfcd_pkg::DIGIT_W-1:0] out_first_digit,
  output logic [cpfcd_pkg::DIGIT_W-1:0] out_second_digit,
  output logic [cpfcd_pkg::FULL_W-1:0]  out_full_number,
  output logic                          out_out_of_range
);

  localparam int N = cpfcd_pkg::BASE_DIGITS;

  // Link k joins cell k-1 to cell k; link 0 is the input port and link N
  // feeds the check unit.
  logic              link_valid [0:N];
  logic              link_stall [0:N];
  cpfcd_pkg::token_t link_tok   [0:N];

  // Seed the token: the remainder starts as the whole base, sums at zero,
  // and flag anything past nine digits here once.
  always_comb begin
    link_valid[0]    = in_valid;
    link_tok[0].base = in_base_number;
    link_tok[0].rest = in_base_number;
    link_tok[0].sum1 = '0;
    link_tok[0].sum2 = '0;
    link_tok[0].oor  = in_base_number > cpfcd_pkg::BASE_LIMIT;
  end

  assign in_stall = link_stall[0];

  // Cell k peels the digit at position k (least significant first), so its
  // weights are k+2 for the first sum and k+3 for the second.
  for (genvar k = 0; k < N; k++) begin : g_cell
    cpfcd_digit_cell #(
      .POS(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_stall (link_stall[k]),
      .up_tok   (link_tok[k]),
      .dn_valid (link_valid[k+1]),
      .dn_stall (link_stall[k+1]),
      .dn_tok   (link_tok[k+1])
    );
  end

  cpfcd_check_unit u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (link_valid[N]),
    .up_stall        (link_stall[N]),
    .up_tok          (link_tok[N]),
    .dn_valid        (out_valid),
    .dn_stall        (out_stall),
    .dn_first_digit  (out_first_digit),
    .dn_second_digit (out_second_digit),
    .dn_full_number  (out_full_number),
    .dn_out_of_range (out_out_of_range)
  );

  // Out-of-range results carry zeros in every numeric field.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_first_digit == '0 && out_second_digit == '0 && out_full_number == '0)
    else $error("out-of-range result carries non-zero digits");

  // Check digits are decimal.
  a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_first_digit <= 4'd9 && out_second_digit <= 4'd9)
    else $error("check digit outside 0..9");

  // Full number stays within eleven decimal digits.
  a_full_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_full_number <= 37'd99999999999)
    else $error("full number exceeds eleven digits");

  // An empty first cell never asks the input to hold.
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> link_valid[1])
    else $error("input stalled while first cell is empty");

endmodule

FILE: rtl/core/cpfcd_digit_cell.sv
// ----------------------------------------------------------------------------
// cpfcd_digit_cell
// One cell of the digit chain: peel off the lowest decimal digit and add its
// weighted value into both running sums.
// ----------------------------------------------------------------------------
module cpfcd_digit_cell #(
  parameter int POS = 0  // decimal position counted from the least significant
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_stall,
  input  cpfcd_pkg::token_t up_tok,
  output logic              dn_valid,
  input  logic              dn_stall,
  output cpfcd_pkg::token_t dn_tok
);

  localparam logic [cpfcd_pkg::SUM_W-1:0] W1 = cpfcd_pkg::SUM_W'(POS + 2);
  localparam logic [cpfcd_pkg::SUM_W-1:0] W2 = cpfcd_pkg::SUM_W'(POS + 3);

  logic [cpfcd_pkg::PROD10_W-1:0] prod;
  logic [cpfcd_pkg::BASE_W-1:0]   quot;
  logic [cpfcd_pkg::BASE_W-1:0]   quot_x10;
  logic [cpfcd_pkg::DIGIT_W-1:0]  digit;
  logic                           advance;
  logic                           valid_r;
  cpfcd_pkg::token_t              tok_r;
  cpfcd_pkg::token_t              tok_nxt;

  always_comb begin
    prod     = cpfcd_pkg::PROD10_W'(up_tok.rest) * cpfcd_pkg::PROD10_W'(cpfcd_pkg::RECIP10);
    quot     = cpfcd_pkg::BASE_W'(prod >> cpfcd_pkg::RECIP10_SHIFT);
    quot_x10 = cpfcd_pkg::BASE_W'((quot << 3) + (quot << 1));
    digit    = cpfcd_pkg::DIGIT_W'(up_tok.rest - quot_x10);
    tok_nxt      = up_tok;
    tok_nxt.rest = quot;
    tok_nxt.sum1 = up_tok.sum1 + cpfcd_pkg::SUM_W'(digit) * W1;
    tok_nxt.sum2 = up_tok.sum2 + cpfcd_pkg::SUM_W'(digit) * W2;
  end

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

endmodule

FILE: rtl/core/cpfcd_check_unit.sv
// ----------------------------------------------------------------------------
// cpfcd_check_unit
// Tail of the chain: reduce both sums mod 11 into check digits and build
// the full number, two register stages.
// ----------------------------------------------------------------------------
module cpfcd_check_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_stall,
  input  cpfcd_pkg::token_t               up_tok,
  output logic                            dn_valid,
  input  logic                            dn_stall,
  output logic [cpfcd_pkg::DIGIT_W-1:0]   dn_first_digit,
  output logic [cpfcd_pkg::DIGIT_W-1:0]   dn_second_digit,
  output logic [cpfcd_pkg::FULL_W-1:0]    dn_full_number,
  output logic                            dn_out_of_range
);

  // first digit stage
  logic                          a_valid_r;
  logic                          a_advance;
  logic [cpfcd_pkg::BASE_W-1:0]  a_base_r;
  logic [cpfcd_pkg::DIGIT_W-1:0] a_d1_r;
  logic [cpfcd_pkg::DIGIT_W-1:0] a_d1_nxt;
  logic [cpfcd_pkg::SUM_W-1:0]   a_sum2_r;
  logic                          a_oor_r;

  // second digit / output stage
  logic                          b_valid_r;
  logic                          b_advance;
  logic [cpfcd_pkg::DIGIT_W-1:0] d2;
  logic [cpfcd_pkg::FULL_W-1:0]  full;
  logic [cpfcd_pkg::DIGIT_W-1:0] b_d1_r;
  logic [cpfcd_pkg::DIGIT_W-1:0] b_d2_r;
  logic [cpfcd_pkg::FULL_W-1:0]  b_full_r;
  logic                          b_oor_r;

  assign b_advance = !b_valid_r || !dn_stall;
  assign a_advance = !a_valid_r || b_advance;
  assign up_stall  = !a_advance;

  assign a_d1_nxt = cpfcd_pkg::digit_from_sum(up_tok.sum1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_advance) begin
      a_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance && up_valid) begin
      a_base_r <= up_tok.base;
      a_d1_r   <= a_d1_nxt;
      a_sum2_r <= up_tok.sum2 + (cpfcd_pkg::SUM_W'(a_d1_nxt) << 1);
      a_oor_r  <= up_tok.oor;
    end
  end

  always_comb begin
    d2   = cpfcd_pkg::digit_from_sum(a_sum2_r);
    full = cpfcd_pkg::FULL_W'(a_base_r) * cpfcd_pkg::FULL_W'(100)
         + cpfcd_pkg::FULL_W'(a_d1_r) * cpfcd_pkg::FULL_W'(10)
         + cpfcd_pkg::FULL_W'(d2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_advance) begin
      b_valid_r <= a_valid_r;
    end
  end

  // out-of-range items report zeros in every numeric field
  always_ff @(posedge clk) begin
    if (b_advance && a_valid_r) begin
      b_d1_r   <= a_oor_r ? '0 : a_d1_r;
      b_d2_r   <= a_oor_r ? '0 : d2;
      b_full_r <= a_oor_r ? '0 : full;
      b_oor_r  <= a_oor_r;
    end
  end

  assign dn_valid        = b_valid_r;
  assign dn_first_digit  = b_d1_r;
  assign dn_second_digit = b_d2_r;
  assign dn_full_number  = b_full_r;
  assign dn_out_of_range = b_oor_r;

endmodule
